### rtl/cfpw_pkg.sv
// ----------------------------------------------------------------------------
// cfpw_pkg
// Shared types, codes and the tag decode of the class file constant pool
// walker.
// ----------------------------------------------------------------------------
package cfpw_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int IN_DEPTH_DEF    = 4;
  localparam int OUT_DEPTH_DEF   = 4;

  localparam int VALUE_BITS  = 64;
  localparam int INDEX_BITS  = 16;
  localparam int TAG_BITS    = 8;
  localparam int LENGTH_BITS = 17;
  localparam int SIZE_BITS   = 4;

  localparam logic [TAG_BITS-1:0] TAG_UTF8          = 8'd1;
  localparam logic [TAG_BITS-1:0] TAG_INTEGER       = 8'd3;
  localparam logic [TAG_BITS-1:0] TAG_FLOAT         = 8'd4;
  localparam logic [TAG_BITS-1:0] TAG_LONG          = 8'd5;
  localparam logic [TAG_BITS-1:0] TAG_DOUBLE        = 8'd6;
  localparam logic [TAG_BITS-1:0] TAG_CLASS         = 8'd7;
  localparam logic [TAG_BITS-1:0] TAG_STRING        = 8'd8;
  localparam logic [TAG_BITS-1:0] TAG_FIELDREF      = 8'd9;
  localparam logic [TAG_BITS-1:0] TAG_METHODREF     = 8'd10;
  localparam logic [TAG_BITS-1:0] TAG_IMETHODREF    = 8'd11;
  localparam logic [TAG_BITS-1:0] TAG_NAME_AND_TYPE = 8'd12;
  localparam logic [TAG_BITS-1:0] TAG_METHOD_HANDLE = 8'd15;
  localparam logic [TAG_BITS-1:0] TAG_METHOD_TYPE   = 8'd16;
  localparam logic [TAG_BITS-1:0] TAG_INVOKE_DYN    = 8'd18;

  localparam logic [SIZE_BITS-1:0] SIZE_NONE  = 4'd0;
  localparam logic [SIZE_BITS-1:0] SIZE_TWO   = 4'd2;
  localparam logic [SIZE_BITS-1:0] SIZE_THREE = 4'd3;
  localparam logic [SIZE_BITS-1:0] SIZE_FOUR  = 4'd4;
  localparam logic [SIZE_BITS-1:0] SIZE_EIGHT = 4'd8;

  typedef enum logic [3:0] {
    KIND_MAGIC   = 4'd0,
    KIND_MINOR   = 4'd1,
    KIND_MAJOR   = 4'd2,
    KIND_PCOUNT  = 4'd3,
    KIND_ENTRY   = 4'd4,
    KIND_ACCESS  = 4'd5,
    KIND_THIS    = 4'd6,
    KIND_SUPER   = 4'd7,
    KIND_ICOUNT  = 4'd8,
    KIND_IFACE   = 4'd9,
    KIND_ERROR   = 4'd10
  } kind_t;

  typedef struct packed {
    logic [7:0]           data;
    logic                 start;
    logic [SIZE_BITS-1:0] tag_len;
  } in_item_t;

  typedef struct packed {
    kind_t                  kind;
    logic [VALUE_BITS-1:0]  value;
    logic [INDEX_BITS-1:0]  index;
    logic [TAG_BITS-1:0]    tag;
    logic [LENGTH_BITS-1:0] length;
    logic                   last;
  } result_t;

  // Payload size that follows a tag byte; zero marks an unknown tag.
  function automatic logic [SIZE_BITS-1:0] tag_size(input logic [TAG_BITS-1:0] t);
    logic [SIZE_BITS-1:0] sz;
    case (t)
      TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: sz = SIZE_TWO;
      TAG_METHOD_HANDLE: sz = SIZE_THREE;
      TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF,
      TAG_NAME_AND_TYPE, TAG_INVOKE_DYN: sz = SIZE_FOUR;
      TAG_LONG, TAG_DOUBLE: sz = SIZE_EIGHT;
      default: sz = SIZE_NONE;
    endcase
    return sz;
  endfunction

endpackage

### rtl/cfpw_front.sv
// ----------------------------------------------------------------------------
// cfpw_front
// Byte intake: decodes the payload size of each byte as a possible tag and
// holds the classified bytes in a short queue for the walker.
// ----------------------------------------------------------------------------
module cfpw_front #(
  parameter int IN_DEPTH = cfpw_pkg::IN_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [7:0]         data_byte,
  input  logic               start_req,
  output logic               full,
  output logic               head_valid,
  output cfpw_pkg::in_item_t head,
  input  logic               head_take
);

  localparam int PTR_W = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam int CNT_W = $clog2(IN_DEPTH + 1);

  cfpw_pkg::in_item_t slots [IN_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == CNT_W'(IN_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = head_take && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr].data    <= data_byte;
      slots[wr_ptr].start   <= start_req;
      slots[wr_ptr].tag_len <= cfpw_pkg::tag_size(data_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(IN_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(IN_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/cfpw_out_fifo.sv
// ----------------------------------------------------------------------------
// cfpw_out_fifo
// Result queue between the walker and the consumer.
// ----------------------------------------------------------------------------
module cfpw_out_fifo #(
  parameter int OFFSET_BITS = cfpw_pkg::OFFSET_BITS_DEF,
  parameter int OUT_DEPTH   = cfpw_pkg::OUT_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  cfpw_pkg::result_t      wr_res,
  input  logic [OFFSET_BITS-1:0] wr_offset,
  output logic                   room,
  output logic                   empty,
  input  logic                   pop,
  output cfpw_pkg::result_t      rd_res,
  output logic [OFFSET_BITS-1:0] rd_offset
);

  localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  cfpw_pkg::result_t      res_mem [OUT_DEPTH];
  logic [OFFSET_BITS-1:0] off_mem [OUT_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;
  logic                   do_push;
  logic                   do_pop;

  assign room      = (count != CNT_W'(OUT_DEPTH));
  assign empty     = (count == '0);
  assign rd_res    = res_mem[rd_ptr];
  assign rd_offset = off_mem[rd_ptr];
  assign do_push   = wr_en && room;
  assign do_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      res_mem[wr_ptr] <= wr_res;
      off_mem[wr_ptr] <= wr_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/cfpw_walker.sv
// ----------------------------------------------------------------------------
// cfpw_walker
// Walks the class header and constant pool one classified byte per cycle
// while the result queue has room, and produces at most one result per byte.
// ----------------------------------------------------------------------------
module cfpw_walker #(
  parameter int OFFSET_BITS = cfpw_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  cfpw_pkg::in_item_t     in_item,
  output logic                   in_take,
  input  logic                   res_room,
  output logic                   res_valid,
  output cfpw_pkg::result_t      res,
  output logic [OFFSET_BITS-1:0] res_offset
);

  typedef enum logic [14:0] {
    PH_IDLE   = 15'h0001,
    PH_MAGIC  = 15'h0002,
    PH_MINOR  = 15'h0004,
    PH_MAJOR  = 15'h0008,
    PH_PCOUNT = 15'h0010,
    PH_TAG    = 15'h0020,
    PH_PAY    = 15'h0040,
    PH_UTF    = 15'h0080,
    PH_ACCESS = 15'h0100,
    PH_THIS   = 15'h0200,
    PH_SUPER  = 15'h0400,
    PH_ICOUNT = 15'h0800,
    PH_IFACE  = 15'h1000,
    PH_DONE   = 15'h2000,
    PH_ERR    = 15'h4000
  } phase_t;

  localparam int VB = cfpw_pkg::VALUE_BITS;
  localparam int IB = cfpw_pkg::INDEX_BITS;
  localparam int TB = cfpw_pkg::TAG_BITS;
  localparam int LB = cfpw_pkg::LENGTH_BITS;

  phase_t                 phase, phase_next, eff_phase;
  logic [LB-1:0]          bytes_left, bytes_left_next, eff_bytes_left;
  logic [IB-1:0]          pool_index, pool_index_next, eff_pool_index;
  logic [IB-1:0]          pool_count, pool_count_next, eff_pool_count;
  logic [TB-1:0]          current_tag, current_tag_next, eff_tag;
  logic [VB-1:0]          gather_value, gather_value_next, eff_gather;
  logic [OFFSET_BITS-1:0] file_offset, file_offset_next, eff_file_offset;
  logic [OFFSET_BITS-1:0] entry_start, entry_start_next, eff_entry_start;
  logic [IB-1:0]          ifaces_left, ifaces_left_next, eff_ifaces_left;

  logic                   active;
  logic [VB-1:0]          shifted;
  logic [LB-1:0]          bytes_dec;
  logic [LB-1:0]          utf_done;
  logic                   entry_fire;
  logic [LB-1:0]          entry_total;
  logic [IB:0]            next_index;
  logic                   wide_tag;

  assign in_take = in_valid && res_room;

  always_comb begin
    if (in_item.start) begin
      eff_phase       = PH_MAGIC;
      eff_bytes_left  = LB'(4);
      eff_pool_index  = IB'(1);
      eff_pool_count  = '0;
      eff_tag         = '0;
      eff_gather      = '0;
      eff_file_offset = '0;
      eff_entry_start = '0;
      eff_ifaces_left = '0;
    end else begin
      eff_phase       = phase;
      eff_bytes_left  = bytes_left;
      eff_pool_index  = pool_index;
      eff_pool_count  = pool_count;
      eff_tag         = current_tag;
      eff_gather      = gather_value;
      eff_file_offset = file_offset;
      eff_entry_start = entry_start;
      eff_ifaces_left = ifaces_left;
    end
  end

  assign active    = (eff_phase != PH_IDLE) && (eff_phase != PH_DONE) && (eff_phase != PH_ERR);
  assign shifted   = {eff_gather[VB-9:0], in_item.data};
  assign bytes_dec = eff_bytes_left - 1'b1;
  assign utf_done  = LB'(2) + {1'b0, eff_ifaces_left} - eff_bytes_left;
  assign wide_tag  = (eff_tag == cfpw_pkg::TAG_LONG) || (eff_tag == cfpw_pkg::TAG_DOUBLE);
  assign next_index = {1'b0, eff_pool_index} + (wide_tag ? (IB+1)'(2) : (IB+1)'(1));

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    pool_index_next   = pool_index;
    pool_count_next   = pool_count;
    current_tag_next  = current_tag;
    gather_value_next = gather_value;
    file_offset_next  = file_offset;
    entry_start_next  = entry_start;
    ifaces_left_next  = ifaces_left;
    res_valid         = 1'b0;
    res               = '0;
    res_offset        = '0;
    entry_fire        = 1'b0;
    entry_total       = '0;

    if (in_take) begin
      phase_next        = eff_phase;
      bytes_left_next   = eff_bytes_left;
      pool_index_next   = eff_pool_index;
      pool_count_next   = eff_pool_count;
      current_tag_next  = eff_tag;
      gather_value_next = eff_gather;
      file_offset_next  = eff_file_offset;
      entry_start_next  = eff_entry_start;
      ifaces_left_next  = eff_ifaces_left;

      if (active) begin
        file_offset_next = eff_file_offset + 1'b1;
        case (eff_phase)
          PH_TAG: begin
            current_tag_next  = in_item.data;
            entry_start_next  = eff_file_offset + 1'b1;
            gather_value_next = '0;
            if (in_item.tag_len == cfpw_pkg::SIZE_NONE) begin
              phase_next = PH_ERR;
              res_valid  = 1'b1;
              res.kind   = cfpw_pkg::KIND_ERROR;
              res.index  = eff_pool_index;
              res.tag    = in_item.data;
              res.last   = 1'b1;
              res_offset = eff_file_offset + 1'b1;
            end else begin
              bytes_left_next = LB'(in_item.tag_len);
              phase_next      = PH_PAY;
            end
          end
          PH_PAY: begin
            gather_value_next = shifted;
            bytes_left_next   = bytes_dec;
            if (bytes_dec == '0) begin
              if (eff_tag == cfpw_pkg::TAG_UTF8) begin
                ifaces_left_next = shifted[IB-1:0];
                if (shifted[IB-1:0] != '0) begin
                  bytes_left_next = {1'b0, shifted[IB-1:0]};
                  phase_next      = PH_UTF;
                end else begin
                  entry_fire  = 1'b1;
                  entry_total = LB'(2);
                end
              end else begin
                entry_fire  = 1'b1;
                entry_total = LB'(cfpw_pkg::tag_size(eff_tag));
              end
            end
          end
          PH_UTF: begin
            if (utf_done < LB'(8)) begin
              gather_value_next = shifted;
            end
            bytes_left_next = bytes_dec;
            if (bytes_dec == '0) begin
              entry_fire  = 1'b1;
              entry_total = LB'(2) + {1'b0, eff_ifaces_left};
            end
          end
          default: begin
            gather_value_next = shifted;
            bytes_left_next   = (eff_bytes_left != '0) ? bytes_dec : '0;
            if (bytes_left_next == '0) begin
              res_valid         = 1'b1;
              res.value         = shifted;
              gather_value_next = '0;
              bytes_left_next   = LB'(2);
              case (eff_phase)
                PH_MAGIC: begin
                  res.kind   = cfpw_pkg::KIND_MAGIC;
                  phase_next = PH_MINOR;
                end
                PH_MINOR: begin
                  res.kind   = cfpw_pkg::KIND_MINOR;
                  phase_next = PH_MAJOR;
                end
                PH_MAJOR: begin
                  res.kind   = cfpw_pkg::KIND_MAJOR;
                  phase_next = PH_PCOUNT;
                end
                PH_PCOUNT: begin
                  res.kind        = cfpw_pkg::KIND_PCOUNT;
                  pool_count_next = shifted[IB-1:0];
                  pool_index_next = IB'(1);
                  if (shifted[IB-1:0] > IB'(1)) begin
                    phase_next      = PH_TAG;
                    bytes_left_next = '0;
                  end else begin
                    phase_next = PH_ACCESS;
                  end
                end
                PH_ACCESS: begin
                  res.kind   = cfpw_pkg::KIND_ACCESS;
                  phase_next = PH_THIS;
                end
                PH_THIS: begin
                  res.kind   = cfpw_pkg::KIND_THIS;
                  phase_next = PH_SUPER;
                end
                PH_SUPER: begin
                  res.kind   = cfpw_pkg::KIND_SUPER;
                  phase_next = PH_ICOUNT;
                end
                PH_ICOUNT: begin
                  res.kind         = cfpw_pkg::KIND_ICOUNT;
                  ifaces_left_next = shifted[IB-1:0];
                  if (shifted[IB-1:0] == '0) begin
                    res.last          = 1'b1;
                    phase_next        = PH_DONE;
                    gather_value_next = shifted;
                    bytes_left_next   = '0;
                  end else begin
                    phase_next = PH_IFACE;
                  end
                end
                default: begin
                  res.kind         = cfpw_pkg::KIND_IFACE;
                  ifaces_left_next = eff_ifaces_left - 1'b1;
                  if (eff_ifaces_left == IB'(1)) begin
                    res.last          = 1'b1;
                    phase_next        = PH_DONE;
                    gather_value_next = shifted;
                    bytes_left_next   = '0;
                  end else begin
                    phase_next = PH_IFACE;
                  end
                end
              endcase
            end
          end
        endcase

        if (entry_fire) begin
          res_valid        = 1'b1;
          res.kind         = cfpw_pkg::KIND_ENTRY;
          res.value        = gather_value_next;
          res.index        = eff_pool_index;
          res.tag          = eff_tag;
          res.length       = entry_total;
          res_offset       = eff_entry_start;
          ifaces_left_next = '0;
          pool_index_next  = next_index[IB-1:0];
          if (next_index >= {1'b0, eff_pool_count}) begin
            phase_next        = PH_ACCESS;
            bytes_left_next   = LB'(2);
            gather_value_next = '0;
          end else begin
            phase_next = PH_TAG;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bytes_left   <= '0;
      pool_index   <= IB'(1);
      pool_count   <= '0;
      current_tag  <= '0;
      gather_value <= '0;
      file_offset  <= '0;
      entry_start  <= '0;
      ifaces_left  <= '0;
    end else begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      pool_index   <= pool_index_next;
      pool_count   <= pool_count_next;
      current_tag  <= current_tag_next;
      gather_value <= gather_value_next;
      file_offset  <= file_offset_next;
      entry_start  <= entry_start_next;
      ifaces_left  <= ifaces_left_next;
    end
  end

endmodule

### rtl/class_file_constant_pool_walker_core.sv
// ----------------------------------------------------------------------------
// class_file_constant_pool_walker_core
// Parses the header and constant pool of a class file streamed one byte
// per transfer and returns one result per header word or pool entry.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake     Payload
//   -------   -----------   ------------------------------------------------
//   input     push / full   data_byte, start_req
//   result    empty / pop   item_kind, field_value, entry_index, entry_tag,
//                           entry_offset, entry_length, last
//
// One byte per cycle is sustained while the result queue has room; a byte
// passes through the input queue to the walker, and its result is written into the result queue.
// The walker stalls only when the result queue is full, and the input queue
// then absorbs up to IN_DEPTH bytes before full rises.
// Reset is synchronous and empties both queues; the walker then ignores
// bytes until one arrives with start_req set.
// ----------------------------------------------------------------------------
module class_file_constant_pool_walker_core #(
  parameter int OFFSET_BITS = cfpw_pkg::OFFSET_BITS_DEF,
  parameter int IN_DEPTH    = cfpw_pkg::IN_DEPTH_DEF,
  parameter int OUT_DEPTH   = cfpw_pkg::OUT_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             data_byte,
  input  logic                   start_req,
  output logic                   empty,
  input  logic                   pop,
  output logic [3:0]             item_kind,
  output logic [63:0]            field_value,
  output logic [15:0]            entry_index,
  output logic [7:0]             entry_tag,
  output logic [OFFSET_BITS-1:0] entry_offset,
  output logic [16:0]            entry_length,
  output logic                   last
);

  logic                   head_valid;
  cfpw_pkg::in_item_t     head;
  logic                   head_take;
  logic                   res_room;
  logic                   res_valid;
  cfpw_pkg::result_t      res;
  logic [OFFSET_BITS-1:0] res_offset;
  cfpw_pkg::result_t      out_res;

  cfpw_front #(
    .IN_DEPTH (IN_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .data_byte  (data_byte),
    .start_req  (start_req),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .head_take  (head_take)
  );

  cfpw_walker #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (head_valid),
    .in_item    (head),
    .in_take    (head_take),
    .res_room   (res_room),
    .res_valid  (res_valid),
    .res        (res),
    .res_offset (res_offset)
  );

  cfpw_out_fifo #(
    .OFFSET_BITS (OFFSET_BITS),
    .OUT_DEPTH   (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (res_valid),
    .wr_res    (res),
    .wr_offset (res_offset),
    .room      (res_room),
    .empty     (empty),
    .pop       (pop),
    .rd_res    (out_res),
    .rd_offset (entry_offset)
  );

  assign item_kind    = out_res.kind;
  assign field_value  = out_res.value;
  assign entry_index  = out_res.index;
  assign entry_tag    = out_res.tag;
  assign entry_length = out_res.length;
  assign last         = out_res.last;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams class files byte by byte into the constant pool walker: a short
// directed header, then random files with valid and unknown tags, restarts,
// truncated files and trailing noise. A scoreboard predicts every result
// from the accepted bytes and compares the popped results field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    S_IDLE, S_MAGIC, S_MINOR, S_MAJOR, S_PCOUNT, S_TAG, S_PAY, S_UTF,
    S_ACCESS, S_THIS, S_SUPER, S_ICOUNT, S_IFACE, S_DONE, S_ERR
  } walk_phase_t;

  typedef struct {
    cfpw_pkg::kind_t kind;
    logic [63:0]     value;
    logic [15:0]     index;
    logic [7:0]      tag;
    logic [31:0]     offset;
    logic [16:0]     length;
    logic            last;
  } walk_result_t;

  class walk_scoreboard;
    walk_phase_t  phase;
    int           bytes_left;
    logic [15:0]  pool_index;
    logic [15:0]  pool_count;
    logic [7:0]   cur_tag;
    logic [63:0]  gather;
    logic [31:0]  file_off;
    logic [31:0]  entry_start;
    logic [15:0]  count_left;
    int           errors;
    walk_result_t walk_results_q[$];

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase       = S_IDLE;
      bytes_left  = 0;
      pool_index  = 16'd1;
      pool_count  = '0;
      cur_tag     = '0;
      gather      = '0;
      file_off    = '0;
      entry_start = '0;
      count_left  = '0;
    endfunction

    static function int tag_bytes(logic [7:0] t);
      int n;
      case (t)
        cfpw_pkg::TAG_UTF8, cfpw_pkg::TAG_CLASS, cfpw_pkg::TAG_STRING,
        cfpw_pkg::TAG_METHOD_TYPE: n = 2;
        cfpw_pkg::TAG_METHOD_HANDLE: n = 3;
        cfpw_pkg::TAG_INTEGER, cfpw_pkg::TAG_FLOAT, cfpw_pkg::TAG_FIELDREF,
        cfpw_pkg::TAG_METHODREF, cfpw_pkg::TAG_IMETHODREF,
        cfpw_pkg::TAG_NAME_AND_TYPE, cfpw_pkg::TAG_INVOKE_DYN: n = 4;
        cfpw_pkg::TAG_LONG, cfpw_pkg::TAG_DOUBLE: n = 8;
        default: n = 0;
      endcase
      return n;
    endfunction

    function walk_result_t blank(cfpw_pkg::kind_t k);
      walk_result_t r;
      r.kind   = k;
      r.value  = '0;
      r.index  = '0;
      r.tag    = '0;
      r.offset = '0;
      r.length = '0;
      r.last   = 1'b0;
      return r;
    endfunction

    function void enter_word(walk_phase_t p, int n);
      phase      = p;
      bytes_left = n;
      gather     = '0;
    endfunction

    function void emit_entry(int total);
      walk_result_t r;
      int           next;
      r        = blank(cfpw_pkg::KIND_ENTRY);
      r.value  = gather;
      r.index  = pool_index;
      r.tag    = cur_tag;
      r.offset = entry_start;
      r.length = 17'(total);
      walk_results_q.push_back(r);
      next = pool_index +
             ((cur_tag == cfpw_pkg::TAG_LONG || cur_tag == cfpw_pkg::TAG_DOUBLE) ? 2 : 1);
      count_left = '0;
      if (next >= pool_count) begin
        enter_word(S_ACCESS, 2);
      end else begin
        phase = S_TAG;
      end
      pool_index = 16'(next);
    endfunction

    function void note_input(logic [7:0] b, logic s);
      walk_result_t r;
      logic [31:0]  off;
      int           sz;
      if (s) begin
        clear();
        enter_word(S_MAGIC, 4);
      end
      if (phase == S_IDLE || phase == S_DONE || phase == S_ERR) return;
      off      = file_off;
      file_off = off + 32'd1;
      case (phase)
        S_TAG: begin
          cur_tag     = b;
          entry_start = off + 32'd1;
          gather      = '0;
          sz          = tag_bytes(b);
          if (sz == 0) begin
            phase    = S_ERR;
            r        = blank(cfpw_pkg::KIND_ERROR);
            r.index  = pool_index;
            r.tag    = b;
            r.offset = entry_start;
            r.last   = 1'b1;
            walk_results_q.push_back(r);
          end else begin
            bytes_left = sz;
            phase      = S_PAY;
          end
          return;
        end
        S_PAY: begin
          gather = {gather[55:0], b};
          bytes_left--;
          if (bytes_left != 0) return;
          if (cur_tag == cfpw_pkg::TAG_UTF8) begin
            count_left = gather[15:0];
            if (count_left != 0) begin
              bytes_left = count_left;
              phase      = S_UTF;
            end else begin
              emit_entry(2);
            end
          end else begin
            emit_entry(tag_bytes(cur_tag));
          end
          return;
        end
        S_UTF: begin
          if (2 + int'(count_left) - bytes_left < 8) gather = {gather[55:0], b};
          bytes_left--;
          if (bytes_left == 0) emit_entry(2 + int'(count_left));
          return;
        end
        default: ;
      endcase
      gather = {gather[55:0], b};
      if (bytes_left != 0) bytes_left--;
      if (bytes_left != 0) return;
      r       = blank(cfpw_pkg::KIND_MAGIC);
      r.value = gather;
      case (phase)
        S_MAGIC: begin
          enter_word(S_MINOR, 2);
        end
        S_MINOR: begin
          r.kind = cfpw_pkg::KIND_MINOR;
          enter_word(S_MAJOR, 2);
        end
        S_MAJOR: begin
          r.kind = cfpw_pkg::KIND_MAJOR;
          enter_word(S_PCOUNT, 2);
        end
        S_PCOUNT: begin
          r.kind     = cfpw_pkg::KIND_PCOUNT;
          pool_count = gather[15:0];
          pool_index = 16'd1;
          if (pool_count > 16'd1) begin
            phase  = S_TAG;
            gather = '0;
          end else begin
            enter_word(S_ACCESS, 2);
          end
        end
        S_ACCESS: begin
          r.kind = cfpw_pkg::KIND_ACCESS;
          enter_word(S_THIS, 2);
        end
        S_THIS: begin
          r.kind = cfpw_pkg::KIND_THIS;
          enter_word(S_SUPER, 2);
        end
        S_SUPER: begin
          r.kind = cfpw_pkg::KIND_SUPER;
          enter_word(S_ICOUNT, 2);
        end
        S_ICOUNT: begin
          r.kind     = cfpw_pkg::KIND_ICOUNT;
          count_left = gather[15:0];
          if (count_left == 0) begin
            r.last = 1'b1;
            phase  = S_DONE;
          end else begin
            enter_word(S_IFACE, 2);
          end
        end
        default: begin
          r.kind     = cfpw_pkg::KIND_IFACE;
          count_left = count_left - 16'd1;
          if (count_left == 0) begin
            r.last = 1'b1;
            phase  = S_DONE;
          end else begin
            enter_word(S_IFACE, 2);
          end
        end
      endcase
      walk_results_q.push_back(r);
    endfunction

    function int pending();
      return walk_results_q.size();
    endfunction

    task report(string what);
      if (errors < 50) $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [3:0] k, logic [63:0] v, logic [15:0] idx, logic [7:0] t,
                      logic [31:0] o, logic [16:0] len, logic l);
      walk_result_t e;
      if (walk_results_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d", k));
        return;
      end
      e = walk_results_q.pop_front();
      if (k !== e.kind) report($sformatf("item_kind %0d, expected %0d", k, e.kind));
      if (v !== e.value) report($sformatf("field_value %h, expected %h", v, e.value));
      if (idx !== e.index) report($sformatf("entry_index %0d, expected %0d", idx, e.index));
      if (t !== e.tag) report($sformatf("entry_tag %0d, expected %0d", t, e.tag));
      if (o !== e.offset) report($sformatf("entry_offset %0d, expected %0d", o, e.offset));
      if (len !== e.length) report($sformatf("entry_length %0d, expected %0d", len, e.length));
      if (l !== e.last) report($sformatf("last %b, expected %b", l, e.last));
    endtask
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        start_req = 1'b0;
  logic        pop       = 1'b0;
  logic        full;
  logic        empty;
  logic [3:0]  item_kind;
  logic [63:0] field_value;
  logic [15:0] entry_index;
  logic [7:0]  entry_tag;
  logic [31:0] entry_offset;
  logic [16:0] entry_length;
  logic        last;

  walk_scoreboard sb = new();
  logic [7:0]     file_bytes[$];
  int             burst_left = 0;
  int             pop_mode   = 0;
  int             mode_left  = 0;

  class_file_constant_pool_walker_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .start_req    (start_req),
    .empty        (empty),
    .pop          (pop),
    .item_kind    (item_kind),
    .field_value  (field_value),
    .entry_index  (entry_index),
    .entry_tag    (entry_tag),
    .entry_offset (entry_offset),
    .entry_length (entry_length),
    .last         (last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        sb.check_result(item_kind, field_value, entry_index, entry_tag, entry_offset,
                        entry_length, last);
      end
      if (push && !full) sb.note_input(data_byte, start_req);
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      pop_mode  = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (pop_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 1) == 1);
      2: pop <= ($urandom_range(0, 9) == 0);
      default: pop <= (mode_left % 24 < 6);
    endcase
  end

  task automatic send_byte(input logic [7:0] d, input logic s);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    push      <= 1'b1;
    data_byte <= d;
    start_req <= s;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_file(input int n);
    for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == 0);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function void put16(logic [15:0] w);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[7:0]);
  endfunction

  function void make_class_file();
    logic [7:0] good_tags[14];
    logic [7:0] t;
    int         pcount;
    int         idx;
    int         len;
    int         nif;
    good_tags = '{cfpw_pkg::TAG_UTF8, cfpw_pkg::TAG_INTEGER, cfpw_pkg::TAG_FLOAT,
                  cfpw_pkg::TAG_LONG, cfpw_pkg::TAG_DOUBLE, cfpw_pkg::TAG_CLASS,
                  cfpw_pkg::TAG_STRING, cfpw_pkg::TAG_FIELDREF, cfpw_pkg::TAG_METHODREF,
                  cfpw_pkg::TAG_IMETHODREF, cfpw_pkg::TAG_NAME_AND_TYPE,
                  cfpw_pkg::TAG_METHOD_HANDLE, cfpw_pkg::TAG_METHOD_TYPE,
                  cfpw_pkg::TAG_INVOKE_DYN};
    file_bytes.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(10, 40)) file_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 1) == 0) begin
      put16(16'hCAFE);
      put16(16'hBABE);
    end else begin
      put16(16'($urandom));
      put16(16'($urandom));
    end
    put16(16'($urandom));
    put16(16'($urandom));
    case ($urandom_range(0, 19))
      0, 1: pcount = $urandom_range(0, 1);
      2: pcount = 16'hFFFF;
      3, 4: pcount = $urandom_range(20, 60);
      default: pcount = $urandom_range(2, 10);
    endcase
    put16(16'(pcount));
    idx = 1;
    while (idx < pcount && idx < 64) begin
      if ($urandom_range(0, 49) == 0) begin
        t = 8'($urandom_range(0, 255));
        while (walk_scoreboard::tag_bytes(t) != 0) t = 8'($urandom_range(0, 255));
        file_bytes.push_back(t);
        repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
        return;
      end
      t = good_tags[$urandom_range(0, 13)];
      file_bytes.push_back(t);
      if (t == cfpw_pkg::TAG_UTF8) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
        put16(16'(len));
        repeat (len) file_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat (walk_scoreboard::tag_bytes(t))
          file_bytes.push_back(8'($urandom_range(0, 255)));
      end
      idx += (t == cfpw_pkg::TAG_LONG || t == cfpw_pkg::TAG_DOUBLE) ? 2 : 1;
    end
    if (idx < pcount) return;
    repeat (3) put16(16'($urandom));
    nif = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    put16(16'(nif));
    repeat (nif) put16(16'($urandom));
  endfunction

  initial begin
    int sent;
    int cut;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bytes before any start are ignored; a start in mid-header restarts.
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    file_bytes = '{8'hCA, 8'hFE, 8'hBA};
    send_file(3);
    file_bytes.delete();
    put16(16'hFFFF);
    put16(16'hFFFF);
    put16(16'h0000);
    put16(16'hFFFF);
    put16(16'h0001);
    put16(16'hFFFF);
    put16(16'h0000);
    put16(16'hFFFF);
    put16(16'h0000);
    send_file(file_bytes.size());
    send_byte(8'h00, 1'b0);
    drain_results();

    sent = 0;
    while (sent < 2000) begin
      make_class_file();
      cut = file_bytes.size();
      if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, cut);
      send_file(cut);
      sent += cut;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
